// ===== rtl/core/mf_pkg.sv =====
package mf_pkg;

    // field widths fixed by the interface
    localparam int PIX_W     = 8;
    localparam int CFG_W     = 13;
    localparam int RB_IN_W   = 12;
    localparam int RC_W      = 13;
    localparam int OUT_ROW_W = 12;

    // register defaults and limits
    localparam int ROW_BYTES_RESET = 640;
    localparam int ROW_COUNT_RESET = 480;
    localparam int ROW_COUNT_MAX   = 4096;

    // register indexes
    localparam logic CFG_ROW_BYTES = 1'b0;
    localparam logic CFG_ROW_COUNT = 1'b1;

    // request kinds
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    typedef logic [PIX_W-1:0] pix_t;

    // per-request control travelling down the pipeline
    typedef struct packed {
        logic emit;
        logic shift;
        logic drain;
        logic inner;
        logic last;
        pix_t pix;
    } tok_t;

endpackage

// ===== rtl/core/median_filter_7x7.sv =====
// Streaming 7x7 median filter on 8-bit pixels in raster order. One request
// (pixel or drain) is taken per clock unless the skid stage is full, set by
// the single write and read port of each line store RAM. The result for a
// pixel is caused by the pixel WINDOW_RADIUS rows plus WINDOW_RADIUS bytes
// later, so the last outputs of a frame are fetched with drain requests. The
// window is a row of column cells fed from 2*WINDOW_RADIUS+1 line RAMs, and
// the median is picked one bit per stage over eight stages. Border pixels
// pass through unchanged. Registers may only be written while the block is
// idle; a write restarts the frame.
module median_filter_7x7 #(
    parameter int MAX_ROW_BYTES = 2048,
    parameter int WINDOW_RADIUS = 3
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     action,
    input  mf_pkg::pix_t             pixel_in,
    output logic                     out_valid,
    input  logic                     out_ready,
    output mf_pkg::pix_t             pixel_out,
    output logic                     frame_last,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic                     cfg_index,
    input  logic [mf_pkg::CFG_W-1:0] cfg_data
);

    localparam int SIDE = 2 * WINDOW_RADIUS + 1;
    localparam int AREA = SIDE * SIDE;
    localparam int MED  = AREA / 2;
    localparam int CW   = $clog2(MAX_ROW_BYTES);
    localparam int BW   = $clog2(MAX_ROW_BYTES + 1);
    localparam int SW   = $clog2(SIDE);
    localparam int SW1  = SW + 1;
    localparam int KW   = $clog2(AREA + 1);
    localparam int LW   = $clog2(WINDOW_RADIUS * (MAX_ROW_BYTES + 1) + 2);
    localparam int NST  = mf_pkg::PIX_W;
    localparam int RB_RESET = (mf_pkg::ROW_BYTES_RESET > MAX_ROW_BYTES) ?
                              MAX_ROW_BYTES : mf_pkg::ROW_BYTES_RESET;

    // configuration
    logic [BW-1:0]              row_bytes_reg, row_bytes_next;
    logic [mf_pkg::RC_W-1:0]    row_count_reg, row_count_next;
    logic                       cfg_wr;
    logic [31:0]                rb_v, rc_v;

    // position counters
    logic [CW-1:0]              in_col_reg, in_col_next;
    logic [mf_pkg::RC_W-1:0]    in_row_reg, in_row_next;
    logic [SW-1:0]              in_slot_reg, in_slot_next;
    logic [CW-1:0]              out_col_reg, out_col_next;
    logic [mf_pkg::OUT_ROW_W-1:0] out_row_reg, out_row_next;
    logic [SW-1:0]              out_slot_reg, out_slot_next;
    logic [LW-1:0]              lead_reg, lead_next;
    logic [LW-1:0]              lag_lim;

    logic adv, accept, frame_in, do_pix, do_drain, emit, inner, last;
    logic in_col_end, out_col_end;

    // pipeline
    mf_pkg::tok_t tok1_reg, tok1_next, tok2_reg, tok2_next, rk_in_tok;
    logic [SW-1:0] s1_in_slot_reg, s1_out_slot_reg;
    logic [SW1-1:0] col_slot;
    mf_pkg::pix_t  ram_rdata [SIDE];
    mf_pkg::pix_t  new_col   [SIDE];
    mf_pkg::pix_t  cell_out  [SIDE][SIDE];
    mf_pkg::pix_t  win_vals  [AREA];

    mf_pkg::pix_t    rk_vals [NST+1][AREA];
    logic [AREA-1:0] rk_mask [NST+1];
    logic [KW-1:0]   rk_k    [NST+1];
    mf_pkg::pix_t    rk_res  [NST+1];
    mf_pkg::tok_t    rk_tok  [NST+1];

    // output register and skid stage
    logic         out_valid_reg, out_valid_next;
    mf_pkg::pix_t out_pix_reg, out_pix_next;
    logic         out_last_reg, out_last_next;
    logic         skid_valid_reg, skid_valid_next;
    mf_pkg::pix_t skid_pix_reg, skid_pix_next;
    logic         skid_last_reg, skid_last_next;
    logic         take, new_res;
    mf_pkg::pix_t new_pix;

    assign adv       = !skid_valid_reg;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid & adv;
    assign cfg_wr    = cfg_valid;

    // register writes with range clamping
    always_comb
    begin
        row_bytes_next = row_bytes_reg;
        row_count_next = row_count_reg;
        rb_v = 32'(cfg_data[mf_pkg::RB_IN_W-1:0]);
        rc_v = 32'(cfg_data[mf_pkg::RC_W-1:0]);
        if (rb_v == 32'd0)
        begin
            rb_v = 32'd1;
        end
        else if (rb_v > 32'(MAX_ROW_BYTES))
        begin
            rb_v = 32'(MAX_ROW_BYTES);
        end
        if (rc_v == 32'd0)
        begin
            rc_v = 32'd1;
        end
        else if (rc_v > 32'(mf_pkg::ROW_COUNT_MAX))
        begin
            rc_v = 32'(mf_pkg::ROW_COUNT_MAX);
        end
        if (cfg_wr)
        begin
            case (cfg_index)
                mf_pkg::CFG_ROW_BYTES: row_bytes_next = BW'(rb_v);
                mf_pkg::CFG_ROW_COUNT: row_count_next = mf_pkg::RC_W'(rc_v);
                default: ;
            endcase
        end
    end

    // request decode and output position checks
    always_comb
    begin
        lag_lim    = LW'(WINDOW_RADIUS * 32'(row_bytes_reg) + WINDOW_RADIUS);
        frame_in   = in_row_reg < row_count_reg;
        do_pix     = accept && (action == mf_pkg::ACT_PIXEL) && frame_in;
        do_drain   = accept && (action == mf_pkg::ACT_DRAIN) && !frame_in;
        emit       = do_drain || (do_pix && (lead_reg >= lag_lim));
        in_col_end = (BW'(in_col_reg) + BW'(1)) >= row_bytes_reg;
        out_col_end = (BW'(out_col_reg) + BW'(1)) >= row_bytes_reg;
        inner = (32'(out_row_reg) >= 32'(WINDOW_RADIUS))
             && (32'(out_row_reg) + 32'(WINDOW_RADIUS) < 32'(row_count_reg))
             && (32'(out_col_reg) >= 32'(WINDOW_RADIUS))
             && (32'(out_col_reg) + 32'(WINDOW_RADIUS) < 32'(row_bytes_reg));
        last  = ((32'(out_row_reg) + 32'd1) == 32'(row_count_reg)) && out_col_end;
    end

    // position counter update
    always_comb
    begin
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        in_slot_next  = in_slot_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        out_slot_next = out_slot_reg;
        lead_next     = lead_reg;
        if (do_pix)
        begin
            if (in_col_end)
            begin
                in_col_next  = '0;
                in_row_next  = in_row_reg + 1'b1;
                in_slot_next = (in_slot_reg == SW'(SIDE - 1)) ? '0 : in_slot_reg + 1'b1;
            end
            else
            begin
                in_col_next = in_col_reg + 1'b1;
            end
            if (!emit)
            begin
                lead_next = lead_reg + 1'b1;
            end
        end
        if (do_drain)
        begin
            lead_next = lead_reg - 1'b1;
        end
        if (emit)
        begin
            if (out_col_end)
            begin
                out_col_next  = '0;
                out_row_next  = out_row_reg + 1'b1;
                out_slot_next = (out_slot_reg == SW'(SIDE - 1)) ? '0 : out_slot_reg + 1'b1;
            end
            else
            begin
                out_col_next = out_col_reg + 1'b1;
            end
        end
        if (cfg_wr || (emit && last))
        begin
            in_col_next   = '0;
            in_row_next   = '0;
            in_slot_next  = '0;
            out_col_next  = '0;
            out_row_next  = '0;
            out_slot_next = '0;
            lead_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg <= BW'(RB_RESET);
            row_count_reg <= mf_pkg::RC_W'(mf_pkg::ROW_COUNT_RESET);
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            in_slot_reg   <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_slot_reg  <= '0;
            lead_reg      <= '0;
        end
        else
        begin
            row_bytes_reg <= row_bytes_next;
            row_count_reg <= row_count_next;
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            in_slot_reg   <= in_slot_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
            out_slot_reg  <= out_slot_next;
            lead_reg      <= lead_next;
        end
    end

    // line store: one RAM per row slot
    for (genvar s = 0; s < SIDE; s++)
    begin : g_line
        mf_ram #(
            .WIDTH(mf_pkg::PIX_W),
            .DEPTH(MAX_ROW_BYTES)
        ) u_ram (
            .clk  (clk),
            .we   (do_pix && (in_slot_reg == SW'(s))),
            .waddr(in_col_reg),
            .wdata(pixel_in),
            .re   (do_pix || do_drain),
            .raddr(do_pix ? in_col_reg : out_col_reg),
            .rdata(ram_rdata[s])
        );
    end

    // stage 1 control
    always_comb
    begin
        tok1_next       = '0;
        tok1_next.emit  = emit;
        tok1_next.shift = do_pix;
        tok1_next.drain = do_drain;
        tok1_next.inner = inner && do_pix;
        tok1_next.last  = last;
        tok1_next.pix   = pixel_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok1_reg <= '0;
            tok2_reg <= '0;
        end
        else if (adv)
        begin
            tok1_reg <= tok1_next;
            tok2_reg <= tok2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_in_slot_reg  <= in_slot_reg;
            s1_out_slot_reg <= out_slot_reg;
        end
    end

    // new column, oldest row first, newest pixel taken straight from the request
    always_comb
    begin
        col_slot = '0;
        for (int j = 0; j < SIDE; j++)
        begin
            if (j == SIDE - 1)
            begin
                new_col[j] = tok1_reg.pix;
            end
            else
            begin
                // slot index wraps round the row ring
                col_slot = SW1'(s1_in_slot_reg) + SW1'(j + 1);
                if (col_slot >= SW1'(SIDE))
                begin
                    col_slot = col_slot - SW1'(SIDE);
                end
                new_col[j] = ram_rdata[col_slot[SW-1:0]];
            end
        end
        tok2_next = tok1_reg;
        if (tok1_reg.drain)
        begin
            tok2_next.pix = ram_rdata[s1_out_slot_reg];
        end
    end

    // window: chain of column cells
    for (genvar c = 0; c < SIDE; c++)
    begin : g_win
        if (c == 0)
        begin : g_head
            mf_col_cell #(.SIDE(SIDE)) u_cell (
                .clk    (clk),
                .shift  (adv && tok1_reg.shift),
                .col_in (new_col),
                .col_out(cell_out[c])
            );
        end
        else
        begin : g_body
            mf_col_cell #(.SIDE(SIDE)) u_cell (
                .clk    (clk),
                .shift  (adv && tok1_reg.shift),
                .col_in (cell_out[c-1]),
                .col_out(cell_out[c])
            );
        end
        for (genvar r = 0; r < SIDE; r++)
        begin : g_flat
            assign win_vals[c*SIDE + r] = cell_out[c][r];
        end
    end

    // pass-through value: drained byte or window centre
    always_comb
    begin
        rk_in_tok = tok2_reg;
        if (!tok2_reg.drain)
        begin
            rk_in_tok.pix = cell_out[WINDOW_RADIUS][WINDOW_RADIUS];
        end
    end

    assign rk_vals[0] = win_vals;
    assign rk_mask[0] = '1;
    assign rk_k[0]    = KW'(MED);
    assign rk_res[0]  = '0;
    assign rk_tok[0]  = rk_in_tok;

    // rank select, one bit per stage from the top
    for (genvar b = 0; b < NST; b++)
    begin : g_rank
        mf_rank_stage #(
            .AREA(AREA),
            .KW  (KW),
            .BIT (NST - 1 - b)
        ) u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv),
            .vals_in (rk_vals[b]),
            .mask_in (rk_mask[b]),
            .k_in    (rk_k[b]),
            .res_in  (rk_res[b]),
            .tok_in  (rk_tok[b]),
            .vals_out(rk_vals[b+1]),
            .mask_out(rk_mask[b+1]),
            .k_out   (rk_k[b+1]),
            .res_out (rk_res[b+1]),
            .tok_out (rk_tok[b+1])
        );
    end

    // output register with skid stage
    always_comb
    begin
        take    = out_valid_reg && out_ready;
        new_res = adv && rk_tok[NST].emit;
        new_pix = rk_tok[NST].inner ? rk_res[NST] : rk_tok[NST].pix;
        out_valid_next  = out_valid_reg;
        out_pix_next    = out_pix_reg;
        out_last_next   = out_last_reg;
        skid_valid_next = skid_valid_reg;
        skid_pix_next   = skid_pix_reg;
        skid_last_next  = skid_last_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_pix_next    = skid_pix_reg;
                out_last_next   = skid_last_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (new_res)
        begin
            if (!out_valid_reg || take)
            begin
                out_valid_next = 1'b1;
                out_pix_next   = new_pix;
                out_last_next  = rk_tok[NST].last;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_pix_next   = new_pix;
                skid_last_next  = rk_tok[NST].last;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_pix_reg   <= out_pix_next;
        out_last_reg  <= out_last_next;
        skid_pix_reg  <= skid_pix_next;
        skid_last_reg <= skid_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign pixel_out  = out_pix_reg;
    assign frame_last = out_last_reg;

endmodule

// ===== rtl/core/mf_ram.sv =====
module mf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/mf_col_cell.sv =====
module mf_col_cell #(
    parameter int SIDE = 7
) (
    input  logic        clk,
    input  logic        shift,
    input  mf_pkg::pix_t col_in  [SIDE],
    output mf_pkg::pix_t col_out [SIDE]
);

    mf_pkg::pix_t col_reg [SIDE];

    // one window column, handed on to the next cell on each shift
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

endmodule

// ===== rtl/core/mf_rank_stage.sv =====
module mf_rank_stage #(
    parameter int AREA = 49,
    parameter int KW   = 6,
    parameter int BIT  = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  mf_pkg::pix_t        vals_in  [AREA],
    input  logic [AREA-1:0]     mask_in,
    input  logic [KW-1:0]       k_in,
    input  mf_pkg::pix_t        res_in,
    input  mf_pkg::tok_t        tok_in,
    output mf_pkg::pix_t        vals_out [AREA],
    output logic [AREA-1:0]     mask_out,
    output logic [KW-1:0]       k_out,
    output mf_pkg::pix_t        res_out,
    output mf_pkg::tok_t        tok_out
);

    logic [AREA-1:0] bit_set;
    logic [KW-1:0]   ones;
    logic            take_one;
    logic [AREA-1:0] mask_next;
    logic [KW-1:0]   k_next;
    mf_pkg::pix_t    res_next;

    mf_pkg::pix_t    vals_reg [AREA];
    logic [AREA-1:0] mask_reg;
    logic [KW-1:0]   k_reg;
    mf_pkg::pix_t    res_reg;
    mf_pkg::tok_t    tok_reg;

    // count candidates with this bit set
    always_comb
    begin
        ones = '0;
        for (int i = 0; i < AREA; i++)
        begin
            bit_set[i] = vals_in[i][BIT];
            ones = ones + KW'(mask_in[i] & vals_in[i][BIT]);
        end
    end

    // decide this bit of the selected value and narrow the candidates
    always_comb
    begin
        take_one = (k_in < ones);
        res_next = res_in;
        res_next[BIT] = take_one;
        if (take_one)
        begin
            mask_next = mask_in & bit_set;
            k_next    = k_in;
        end
        else
        begin
            mask_next = mask_in & ~bit_set;
            k_next    = k_in - ones;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else if (en)
        begin
            tok_reg <= tok_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vals_reg <= vals_in;
            mask_reg <= mask_next;
            k_reg    <= k_next;
            res_reg  <= res_next;
        end
    end

    assign vals_out = vals_reg;
    assign mask_out = mask_reg;
    assign k_out    = k_reg;
    assign res_out  = res_reg;
    assign tok_out  = tok_reg;

endmodule
